[hw/rtl/dsk_pkg.sv]
// dsk_pkg: shared types and constants for the sector disk block
// used by every module under hw/rtl; depends on nothing else
`default_nettype none

package dsk_pkg;

   // default sizes of the disk, handed to the top-level parameters
   localparam int DEF_MAX_CYLINDERS = 64;
   localparam int DEF_MAX_SECTORS   = 16;
   localparam int DEF_SECTOR_BYTES  = 128;

   // fixed field widths
   localparam int CYL_IN_W   = 11;
   localparam int SEC_IN_W   = 11;
   localparam int LEN_IN_W   = 9;
   localparam int WORD_W     = 64;
   localparam int SEEK_W     = 26;
   localparam int NCYL_W     = 7;
   localparam int NSEC_W     = 5;
   localparam int TRACK_W    = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // request operation codes
   typedef enum logic [1:0] {
      OP_INFO     = 2'd0,
      OP_READ     = 2'd1,
      OP_WR_START = 2'd2,
      OP_WR_DATA  = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_CYL    = 2'd0,
      CSR_NUM_SEC    = 2'd1,
      CSR_TRACK_TIME = 2'd2
   } csr_idx_type;

   // one response item
   typedef struct packed {
      logic              ok;
      logic [WORD_W-1:0] word;
      logic              last;
      logic [SEEK_W-1:0] seek;
      logic [NCYL_W-1:0] rc;
      logic [NSEC_W-1:0] rs;
   } rsp_type;

   // memory strobes from the sequencer to the store
   typedef struct packed {
      logic clr;
      logic cmt_wr;
      logic rd;
      logic buf_wr;
      logic buf_rd;
   } mem_ctl_type;

   // response queue status seen by the sequencer
   typedef struct packed {
      logic [1:0] count;
      logic       pop;
   } q_stat_type;

endpackage

`default_nettype wire

[hw/rtl/dsk_store.sv]
// dsk_store: sector memory and one-sector write buffer, with commit byte masking
// depends on dsk_pkg; driven by dsk_seq
`default_nettype none

module dsk_store
   import dsk_pkg::*;
#(
   parameter int MAX_CYLINDERS = DEF_MAX_CYLINDERS,
   parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
   parameter int SECTOR_BYTES  = DEF_SECTOR_BYTES
) (
   input  wire logic                                         clock,
   input  wire mem_ctl_type                                  ctl,
   input  wire logic [$clog2(MAX_CYLINDERS*MAX_SECTORS*((SECTOR_BYTES+7)/8))-1:0] rd_addr,
   input  wire logic [$clog2(MAX_CYLINDERS*MAX_SECTORS*((SECTOR_BYTES+7)/8))-1:0] wr_addr,
   input  wire logic [(((SECTOR_BYTES+7)/8) > 1 ? $clog2((SECTOR_BYTES+7)/8) : 1)-1:0] buf_wr_idx,
   input  wire logic [(((SECTOR_BYTES+7)/8) > 1 ? $clog2((SECTOR_BYTES+7)/8) : 1)-1:0] buf_rd_idx,
   input  wire logic [WORD_W-1:0]                            buf_wdata,
   input  wire logic [(((SECTOR_BYTES+7)/8) > 1 ? $clog2((SECTOR_BYTES+7)/8) : 1)-1:0] cmt_k,
   input  wire logic [$clog2(SECTOR_BYTES+1)-1:0]            cmt_len,
   output      logic [WORD_W-1:0]                            rd_data
);

   localparam int WORDS  = (SECTOR_BYTES + 7) / 8;
   localparam int DEPTH  = MAX_CYLINDERS * MAX_SECTORS * WORDS;
   localparam int KW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LEN_W  = $clog2(SECTOR_BYTES + 1);
   localparam int CMP_W  = KW + LEN_W + 4;

   logic [WORD_W-1:0] sector_mem [DEPTH];
   logic [WORD_W-1:0] buf_mem [WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic [WORD_W-1:0] buf_q_ff;
   logic [WORD_W-1:0] cmt_word;
   logic [WORD_W-1:0] wr_data;
   logic [KW+2:0]     byte_idx;

   // keep only the bytes that lie below the write length
   always_comb begin
      cmt_word = buf_q_ff;
      byte_idx = '0;
      for (int j = 0; j < 8; j++) begin
         byte_idx = {cmt_k, 3'(j)};
         if (CMP_W'(byte_idx) >= CMP_W'(cmt_len)) begin
            cmt_word[8*j +: 8] = 8'd0;
         end
      end
   end

   assign wr_data = ctl.clr ? '0 : cmt_word;

   // sector memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.clr || ctl.cmt_wr) begin
         sector_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd) begin
         rd_data_ff <= sector_mem[rd_addr];
      end
   end

   // write buffer: filled by data words, swept out on commit
   always_ff @(posedge clock) begin
      if (ctl.buf_wr) begin
         buf_mem[buf_wr_idx] <= buf_wdata;
      end
      if (ctl.buf_rd) begin
         buf_q_ff <= buf_mem[buf_rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/dsk_rspq.sv]
// dsk_rspq: two-entry response queue between the sequencer and the rsp_ stream
// depends on dsk_pkg
`default_nettype none

module dsk_rspq
   import dsk_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output      logic    out_valid,
   input  wire logic    out_ready,
   output      rsp_type out_data,
   output      q_stat_type stat
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       pop;

   assign out_valid = (cnt_ff != 2'd0);
   assign pop       = out_valid & out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign stat.count = cnt_ff;
   assign stat.pop   = pop;

endmodule

`default_nettype wire

[hw/rtl/dsk_seq.sv]
// dsk_seq: command sequencer, geometry registers, head position and seek timing
// depends on dsk_pkg; drives dsk_store and dsk_rspq
`default_nettype none

module dsk_seq
   import dsk_pkg::*;
#(
   parameter int MAX_CYLINDERS = DEF_MAX_CYLINDERS,
   parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
   parameter int SECTOR_BYTES  = DEF_SECTOR_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [1:0]            req_op,
   input  wire logic [CYL_IN_W-1:0]   req_cyl,
   input  wire logic [SEC_IN_W-1:0]   req_sec,
   input  wire logic [LEN_IN_W-1:0]   req_len,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire q_stat_type            q_stat,
   output      logic                  push,
   output      rsp_type               push_data,
   output      mem_ctl_type           ctl,
   output      logic [$clog2(MAX_CYLINDERS*MAX_SECTORS*((SECTOR_BYTES+7)/8))-1:0] rd_addr,
   output      logic [$clog2(MAX_CYLINDERS*MAX_SECTORS*((SECTOR_BYTES+7)/8))-1:0] wr_addr,
   output      logic [(((SECTOR_BYTES+7)/8) > 1 ? $clog2((SECTOR_BYTES+7)/8) : 1)-1:0] buf_wr_idx,
   output      logic [(((SECTOR_BYTES+7)/8) > 1 ? $clog2((SECTOR_BYTES+7)/8) : 1)-1:0] buf_rd_idx,
   output      logic [(((SECTOR_BYTES+7)/8) > 1 ? $clog2((SECTOR_BYTES+7)/8) : 1)-1:0] cmt_k,
   output      logic [$clog2(SECTOR_BYTES+1)-1:0] cmt_len,
   input  wire logic [WORD_W-1:0]     rd_data
);

   localparam int WORDS  = (SECTOR_BYTES + 7) / 8;
   localparam int DEPTH  = MAX_CYLINDERS * MAX_SECTORS * WORDS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int KW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W  = $clog2(WORDS + 1);
   localparam int LEN_W  = $clog2(SECTOR_BYTES + 1);
   localparam int NW     = LEN_W + 1;
   localparam int CYL_W  = (MAX_CYLINDERS > 1) ? $clog2(MAX_CYLINDERS) : 1;
   localparam int SEC_W  = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
   localparam int LW     = CYL_W + NSEC_W + 1;
   localparam int LIN_W  = (MAX_CYLINDERS * MAX_SECTORS > 1) ?
                           $clog2(MAX_CYLINDERS * MAX_SECTORS) : 1;

   localparam logic [NCYL_W-1:0] NCYL_CAP = NCYL_W'((MAX_CYLINDERS > 127) ? 127 : MAX_CYLINDERS);
   localparam logic [NSEC_W-1:0] NSEC_CAP = NSEC_W'((MAX_SECTORS > 31) ? 31 : MAX_SECTORS);
   localparam logic [NCYL_W-1:0] NCYL_RST = NCYL_W'((64 > MAX_CYLINDERS) ? MAX_CYLINDERS : 64);
   localparam logic [NSEC_W-1:0] NSEC_RST = NSEC_W'((16 > MAX_SECTORS) ? MAX_SECTORS : 16);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [KW-1:0]     K_LAST   = KW'(WORDS - 1);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_LIN    = 7'b0000100,
      ST_BASE   = 7'b0001000,
      ST_READ   = 7'b0010000,
      ST_COMMIT = 7'b0100000,
      ST_RESP   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [NCYL_W-1:0]  ncyl_ff;
   logic [NSEC_W-1:0]  nsec_ff;
   logic [TRACK_W-1:0] track_ff;
   logic [CYL_W-1:0]   head_ff;
   logic               pend_ff, pend_in;
   logic [CYL_W-1:0]   tgt_cyl_ff, tgt_cyl_in;
   logic [SEC_W-1:0]   tgt_sec_ff, tgt_sec_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   wcnt_ff, wcnt_in;
   logic               do_cmt_ff, do_cmt_in;
   logic [LIN_W-1:0]   lin_ff;
   logic [CYL_W-1:0]   dist_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [SEEK_W-1:0]  seek_ff;
   logic [KW-1:0]      k_ff, k_in;
   logic               inflight_ff;
   logic               infl_last_ff;
   logic               cmt_vld_ff;
   logic [KW-1:0]      cmt_k_ff;
   logic               resp_ok_ff, resp_ok_in;
   logic               resp_info_ff, resp_info_in;
   logic               resp_cmt_ff, resp_cmt_in;

   op_type              op;
   logic                acc;
   logic                addr_ok;
   logic                len_ok;
   logic                can_issue;
   logic [NW-1:0]       need;
   logic [NW-1:0]       wcnt_next;
   logic [LW-1:0]       lin_full;
   logic [CYL_W-1:0]    dist_next;
   logic [CYL_W+TRACK_W-1:0] seek_prod;
   logic [NCYL_W-1:0]   ncyl_wr;
   logic [NSEC_W-1:0]   nsec_wr;

   assign op        = op_type'(req_op);
   assign req_ready = (state_ff == ST_IDLE);
   assign acc       = req_valid & req_ready;

   // address and length checks against the current geometry
   assign addr_ok = !req_cyl[CYL_IN_W-1] && (req_cyl[CYL_IN_W-2:0] < {3'b000, ncyl_ff}) &&
                    !req_sec[SEC_IN_W-1] && (req_sec[SEC_IN_W-2:0] < {5'b00000, nsec_ff});
   assign len_ok  = !req_len[LEN_IN_W-1] && (32'(req_len[LEN_IN_W-2:0]) <= SECTOR_BYTES);

   // data words still owed by a pending write
   assign need      = (NW'(len_ff) + NW'(7)) >> 3;
   assign wcnt_next = NW'(wcnt_ff) + NW'(1);

   // room in the response queue, counting a read still in the memory
   assign can_issue = ({1'b0, q_stat.count} + {2'b00, inflight_ff}) <= (3'd1 + {2'b00, q_stat.pop});

   // sector index, seek distance and seek product
   assign lin_full  = LW'(tgt_cyl_ff) * LW'(nsec_ff) + LW'(tgt_sec_ff);
   assign dist_next = (tgt_cyl_ff >= head_ff) ? (tgt_cyl_ff - head_ff) : (head_ff - tgt_cyl_ff);
   assign seek_prod = (CYL_W+TRACK_W)'(dist_ff) * (CYL_W+TRACK_W)'(track_ff);

   // sequencer next state and memory strobes
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      tgt_cyl_in   = tgt_cyl_ff;
      tgt_sec_in   = tgt_sec_ff;
      len_in       = len_ff;
      wcnt_in      = wcnt_ff;
      do_cmt_in    = do_cmt_ff;
      k_in         = k_ff;
      resp_ok_in   = resp_ok_ff;
      resp_info_in = resp_info_ff;
      resp_cmt_in  = resp_cmt_ff;
      ctl          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clr = 1'b1;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc) begin
               if (op != OP_WR_DATA) begin
                  pend_in = 1'b0;
               end
               unique case (op)
                  OP_INFO: begin
                     resp_ok_in   = 1'b1;
                     resp_info_in = 1'b1;
                     resp_cmt_in  = 1'b0;
                     state_in     = ST_RESP;
                  end
                  OP_READ: begin
                     if (addr_ok) begin
                        tgt_cyl_in = req_cyl[CYL_W-1:0];
                        tgt_sec_in = req_sec[SEC_W-1:0];
                        do_cmt_in  = 1'b0;
                        state_in   = ST_LIN;
                     end else begin
                        resp_ok_in   = 1'b0;
                        resp_info_in = 1'b0;
                        resp_cmt_in  = 1'b0;
                        state_in     = ST_RESP;
                     end
                  end
                  OP_WR_START: begin
                     if (addr_ok && len_ok) begin
                        tgt_cyl_in = req_cyl[CYL_W-1:0];
                        tgt_sec_in = req_sec[SEC_W-1:0];
                        len_in     = LEN_W'(req_len[LEN_IN_W-2:0]);
                        wcnt_in    = '0;
                        if (req_len[LEN_IN_W-2:0] == '0) begin
                           do_cmt_in = 1'b1;
                           state_in  = ST_LIN;
                        end else begin
                           pend_in = 1'b1;
                        end
                     end else begin
                        resp_ok_in   = 1'b0;
                        resp_info_in = 1'b0;
                        resp_cmt_in  = 1'b0;
                        state_in     = ST_RESP;
                     end
                  end
                  OP_WR_DATA: begin
                     // a data word with nothing pending is dropped
                     if (pend_ff) begin
                        ctl.buf_wr = 1'b1;
                        wcnt_in    = CNT_W'(wcnt_next);
                        if (wcnt_next >= need) begin
                           pend_in   = 1'b0;
                           do_cmt_in = 1'b1;
                           state_in  = ST_LIN;
                        end
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LIN: begin
            state_in = ST_BASE;
         end
         ST_BASE: begin
            k_in     = '0;
            state_in = do_cmt_ff ? ST_COMMIT : ST_READ;
         end
         ST_READ: begin
            if (can_issue) begin
               ctl.rd = 1'b1;
               k_in   = k_ff + KW'(1);
               if (k_ff == K_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_COMMIT: begin
            ctl.buf_rd = 1'b1;
            k_in       = k_ff + KW'(1);
            if (k_ff == K_LAST) begin
               resp_ok_in   = 1'b1;
               resp_info_in = 1'b0;
               resp_cmt_in  = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!inflight_ff && can_issue) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ctl.cmt_wr = cmt_vld_ff;
   end

   // memory addresses; the commit write comes in the cycle after its buffer read
   assign rd_addr    = base_ff + ADDR_W'(k_ff);
   assign wr_addr    = (state_ff == ST_CLEAR) ? clr_ff : (base_ff + ADDR_W'(cmt_k_ff));
   assign buf_wr_idx = wcnt_ff[KW-1:0];
   assign buf_rd_idx = k_ff;
   assign cmt_k      = cmt_k_ff;
   assign cmt_len    = len_ff;

   // response push: read words returning from memory, or a single response
   always_comb begin
      push_data = '0;
      if (inflight_ff) begin
         push           = 1'b1;
         push_data.ok   = 1'b1;
         push_data.word = rd_data;
         push_data.last = infl_last_ff;
         push_data.seek = seek_ff;
      end else begin
         push           = (state_ff == ST_RESP) && can_issue;
         push_data.ok   = resp_ok_ff;
         push_data.last = 1'b1;
         push_data.seek = resp_cmt_ff ? seek_ff : '0;
         push_data.rc   = resp_info_ff ? ncyl_ff : '0;
         push_data.rs   = resp_info_ff ? nsec_ff : '0;
      end
   end

   // geometry writes saturate at the configured maximum
   assign ncyl_wr = csr_wdata[NCYL_W-1:0];
   assign nsec_wr = csr_wdata[NSEC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ncyl_ff  <= NCYL_RST;
         nsec_ff  <= NSEC_RST;
         track_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_NUM_CYL: begin
               ncyl_ff <= (32'(ncyl_wr) > MAX_CYLINDERS) ? NCYL_CAP : ncyl_wr;
            end
            CSR_NUM_SEC: begin
               nsec_ff <= (32'(nsec_wr) > MAX_SECTORS) ? NSEC_CAP : nsec_wr;
            end
            CSR_TRACK_TIME: begin
               track_ff <= csr_wdata[TRACK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         pend_ff     <= 1'b0;
         wcnt_ff     <= '0;
         head_ff     <= '0;
         inflight_ff <= 1'b0;
         cmt_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         pend_ff     <= pend_in;
         wcnt_ff     <= wcnt_in;
         inflight_ff <= ctl.rd;
         cmt_vld_ff  <= ctl.buf_rd;
         if (state_ff == ST_LIN) begin
            head_ff <= tgt_cyl_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tgt_cyl_ff   <= tgt_cyl_in;
      tgt_sec_ff   <= tgt_sec_in;
      len_ff       <= len_in;
      do_cmt_ff    <= do_cmt_in;
      k_ff         <= k_in;
      resp_ok_ff   <= resp_ok_in;
      resp_info_ff <= resp_info_in;
      resp_cmt_ff  <= resp_cmt_in;
      infl_last_ff <= (k_ff == K_LAST);
      cmt_k_ff     <= k_ff;
      if (state_ff == ST_LIN) begin
         lin_ff  <= LIN_W'(lin_full);
         dist_ff <= dist_next;
      end
      if (state_ff == ST_BASE) begin
         base_ff <= ADDR_W'(ADDR_W'(lin_ff) * ADDR_W'(WORDS));
         seek_ff <= SEEK_W'(seek_prod);
      end
   end

endmodule

`default_nettype wire

[hw/rtl/sector_disk_with_seek_timing.sv]
// Simulated sector disk: after reset the block clears the sector memory one
// store word at a time (MAX_CYLINDERS*MAX_SECTORS*ceil(SECTOR_BYTES/8) words,
// 16384 at the defaults) and takes no request until that pass ends. It then
// serves one request at a time. An info request or a rejected request answers
// from the RESP state. An accepted read works out sector address and seek time
// in the LIN and BASE states, then streams one word per cycle from the single
// read port of the sector memory, ceil(SECTOR_BYTES/8) words in all (16 by
// default), slowed only by backpressure on the response side. A write data word
// goes into the write buffer when taken; the last one, or a write start of
// length zero, commits the buffered sector through the LIN, BASE and COMMIT
// states, one word per cycle through the memory write port, and answers with its
// seek time. Seek time is the cylinder distance times track_time_us, kept to 26
// bits. Commands run strictly in order, so a read never overlaps a commit to the
// same sector. Depends on dsk_pkg, dsk_seq, dsk_store and dsk_rspq.
`default_nettype none

module sector_disk_with_seek_timing
   import dsk_pkg::*;
#(
   parameter int MAX_CYLINDERS = DEF_MAX_CYLINDERS,
   parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
   parameter int SECTOR_BYTES  = DEF_SECTOR_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [95:0]           req_tdata,  // cylinder, sector, length, data_word
   input  wire logic [1:0]            req_tuser,  // operation
   // response stream
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [103:0]          rsp_tdata,  // read_word, seek_time_us,
                                                  // reported_cylinders, reported_sectors
   output      logic                  rsp_tuser,  // ok
   output      logic                  rsp_tlast,  // last
   // configuration writes
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WORDS  = (SECTOR_BYTES + 7) / 8;
   localparam int ADDR_W = $clog2(MAX_CYLINDERS * MAX_SECTORS * WORDS);
   localparam int KW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LEN_W  = $clog2(SECTOR_BYTES + 1);

   logic [CYL_IN_W-1:0] req_cyl;
   logic [SEC_IN_W-1:0] req_sec;
   logic [LEN_IN_W-1:0] req_len;
   logic [WORD_W-1:0]   req_word;

   q_stat_type         q_stat;
   logic               push;
   rsp_type            push_data;
   rsp_type            out_data;
   mem_ctl_type        ctl;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [KW-1:0]      buf_wr_idx;
   logic [KW-1:0]      buf_rd_idx;
   logic [KW-1:0]      cmt_k;
   logic [LEN_W-1:0]   cmt_len;
   logic [WORD_W-1:0]  rd_data;

   // request field unpacking
   assign req_cyl  = req_tdata[10:0];
   assign req_sec  = req_tdata[21:11];
   assign req_len  = req_tdata[30:22];
   assign req_word = req_tdata[94:31];

   dsk_seq #(
      .MAX_CYLINDERS (MAX_CYLINDERS),
      .MAX_SECTORS   (MAX_SECTORS),
      .SECTOR_BYTES  (SECTOR_BYTES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_cyl    (req_cyl),
      .req_sec    (req_sec),
      .req_len    (req_len),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data),
      .ctl        (ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .buf_wr_idx (buf_wr_idx),
      .buf_rd_idx (buf_rd_idx),
      .cmt_k      (cmt_k),
      .cmt_len    (cmt_len),
      .rd_data    (rd_data)
   );

   dsk_store #(
      .MAX_CYLINDERS (MAX_CYLINDERS),
      .MAX_SECTORS   (MAX_SECTORS),
      .SECTOR_BYTES  (SECTOR_BYTES)
   ) u_store (
      .clock      (clock),
      .ctl        (ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .buf_wr_idx (buf_wr_idx),
      .buf_rd_idx (buf_rd_idx),
      .buf_wdata  (req_word),
      .cmt_k      (cmt_k),
      .cmt_len    (cmt_len),
      .rd_data    (rd_data)
   );

   dsk_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .stat      (q_stat)
   );

   // response field packing
   assign rsp_tdata = {2'b00, out_data.rs, out_data.rc, out_data.seek, out_data.word};
   assign rsp_tuser = out_data.ok;
   assign rsp_tlast = out_data.last;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// testbench: self-checking bench for sector_disk_with_seek_timing (disk of sectors with seek time)
// queued request driver, response monitor and an in-bench disk predictor; uses dsk_pkg

module testbench;
   import dsk_pkg::*;

   localparam int WORDS_PER_SECTOR = (DEF_SECTOR_BYTES + 7) / 8;
   localparam int STORE_DEPTH      = DEF_MAX_CYLINDERS * DEF_MAX_SECTORS * WORDS_PER_SECTOR;
   localparam int COMMIT_CYCLES    = 2 + WORDS_PER_SECTOR + 1 + 12;
   localparam int MAX_REPORTS      = 10;

   // one request item as queued for the driver
   typedef struct {
      op_type              op;
      logic [CYL_IN_W-1:0] cyl;
      logic [SEC_IN_W-1:0] sec;
      logic [LEN_IN_W-1:0] len;
      logic [WORD_W-1:0]   data;
   } disk_request;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [95:0]           req_tdata = '0;      // cylinder, sector, length, data_word
   logic [1:0]            req_tuser = OP_INFO; // operation
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [103:0]          rsp_tdata;           // read_word, seek_time_us,
                                               // reported_cylinders, reported_sectors
   wire                   rsp_tuser;           // ok
   wire                   rsp_tlast;           // last
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_NUM_CYL;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sector_disk_with_seek_timing dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // disk predictor state and its copy of the registers
   logic [WORD_W-1:0] disk_image [STORE_DEPTH];
   logic [WORD_W-1:0] write_buffer [WORDS_PER_SECTOR];
   int geo_cylinders = DEF_MAX_CYLINDERS;
   int geo_sectors   = DEF_MAX_SECTORS;
   int track_step    = 0;
   int head_cyl      = 0;
   bit write_open    = 1'b0;
   int write_cyl, write_sec, write_len, write_words;

   rsp_type     expected_responses [$];
   disk_request pending_requests [$];
   disk_request next_req;

   // handshake bookkeeping between the edges
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit rsp_blocked = 1'b0;
   int req_wait = 0;
   int rsp_wait = 0;
   int req_gap_max = 0;
   int rsp_gap_max = 0;

   // run statistics
   int error_count = 0;
   int request_count = 0;
   int response_count = 0;
   int read_count = 0;
   int commit_count = 0;
   int reject_count = 0;
   int setting_count = 1;

   function automatic int draw_gap(int max_gap);
      if (max_gap > 0 && $urandom_range(0, 1) == 1)
         return $urandom_range(0, max_gap);
      return 0;
   endfunction

   function automatic bit address_valid(int c, int s);
      return c >= 0 && c < geo_cylinders && s >= 0 && s < geo_sectors;
   endfunction

   // track distance times track time, head moves to the new cylinder
   function automatic logic [SEEK_W-1:0] seek_to(int c);
      longint span;
      span = (c >= head_cyl) ? c - head_cyl : head_cyl - c;
      head_cyl = c;
      return SEEK_W'(span * longint'(track_step));
   endfunction

   function automatic void push_reject();
      rsp_type r;
      r = '0;
      r.last = 1'b1;
      expected_responses.push_back(r);
      reject_count++;
   endfunction

   // store the buffered sector with bytes past the length cleared
   function automatic void commit_sector();
      int base, first;
      logic [WORD_W-1:0] w;
      rsp_type r;
      base = (write_cyl * geo_sectors + write_sec) * WORDS_PER_SECTOR;
      for (int k = 0; k < WORDS_PER_SECTOR; k++) begin
         first = k * 8;
         w = write_buffer[k];
         if (first >= write_len)
            w = '0;
         else if (write_len - first < 8)
            w &= (64'd1 << (8 * (write_len - first))) - 64'd1;
         disk_image[base + k] = w;
      end
      write_open = 1'b0;
      r = '0;
      r.ok = 1'b1;
      r.last = 1'b1;
      r.seek = seek_to(write_cyl);
      expected_responses.push_back(r);
      commit_count++;
   endfunction

   // apply one taken request to the disk and queue the responses it causes
   function automatic void disk_apply_request(op_type op, logic signed [CYL_IN_W-1:0] cyl,
         logic signed [SEC_IN_W-1:0] sec, logic signed [LEN_IN_W-1:0] len,
         logic [WORD_W-1:0] data);
      int c, s, n, base;
      logic [SEEK_W-1:0] seek;
      rsp_type r;
      c = cyl;
      s = sec;
      n = len;
      r = '0;
      request_count++;
      if (op == OP_WR_DATA) begin
         if (!write_open)
            return;
         if (write_words < WORDS_PER_SECTOR)
            write_buffer[write_words] = data;
         write_words++;
         if (write_words >= (write_len + 7) / 8)
            commit_sector();
         return;
      end
      // any other command drops a write still in progress
      write_open = 1'b0;
      case (op)
         OP_INFO: begin
            r.ok = 1'b1;
            r.last = 1'b1;
            r.rc = geo_cylinders[NCYL_W-1:0];
            r.rs = geo_sectors[NSEC_W-1:0];
            expected_responses.push_back(r);
         end
         OP_READ: begin
            if (!address_valid(c, s)) begin
               push_reject();
            end else begin
               seek = seek_to(c);
               base = (c * geo_sectors + s) * WORDS_PER_SECTOR;
               for (int k = 0; k < WORDS_PER_SECTOR; k++) begin
                  r.ok = 1'b1;
                  r.word = disk_image[base + k];
                  r.last = (k == WORDS_PER_SECTOR - 1);
                  r.seek = seek;
                  expected_responses.push_back(r);
               end
               read_count++;
            end
         end
         default: begin
            if (!address_valid(c, s) || n < 0 || n > DEF_SECTOR_BYTES) begin
               push_reject();
            end else begin
               write_open = 1'b1;
               write_cyl = c;
               write_sec = s;
               write_len = n;
               write_words = 0;
               foreach (write_buffer[k]) write_buffer[k] = '0;
               if (n == 0)
                  commit_sector();
            end
         end
      endcase
   endfunction

   // request driver: offers queued requests, holds each until taken
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_wait > 0) begin
            req_wait--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            next_req = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, next_req.data, next_req.len, next_req.sec, next_req.cyl};
            req_tuser  <= next_req.op;
            req_wait = draw_gap(req_gap_max);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready: random stalls per response, plus the long hold-off
   always @(negedge clock) begin
      if (rsp_taken)
         rsp_wait = draw_gap(rsp_gap_max);
      if (rsp_blocked) begin
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on each taken request, check each taken response
   always @(posedge clock) begin
      rsp_type got, want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            disk_apply_request(op_type'(req_tuser), req_tdata[10:0], req_tdata[21:11],
                               req_tdata[30:22], req_tdata[94:31]);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            response_count++;
            got.ok   = rsp_tuser;
            got.word = rsp_tdata[63:0];
            got.last = rsp_tlast;
            got.seek = rsp_tdata[89:64];
            got.rc   = rsp_tdata[96:90];
            got.rs   = rsp_tdata[101:97];
            if (expected_responses.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected response ok=%0b word=%h last=%0b seek=%0d",
                           $realtime, got.ok, got.word, got.last, got.seek);
            end else begin
               want = expected_responses.pop_front();
               if (got.ok !== want.ok || got.word !== want.word || got.last !== want.last ||
                   got.seek !== want.seek || got.rc !== want.rc || got.rs !== want.rs) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("  expected ok=%0b word=%h last=%0b seek=%0d cyls=%0d secs=%0d",
                              want.ok, want.word, want.last, want.seek, want.rc, want.rs);
                     $display("  actual   ok=%0b word=%h last=%0b seek=%0d cyls=%0d secs=%0d",
                              got.ok, got.word, got.last, got.seek, got.rc, got.rs);
                  end
               end
            end
         end
      end
   end

   task automatic queue_request(op_type op, int cyl, int sec, int len, logic [WORD_W-1:0] data);
      disk_request q;
      q.op   = op;
      q.cyl  = cyl[CYL_IN_W-1:0];
      q.sec  = sec[SEC_IN_W-1:0];
      q.len  = len[LEN_IN_W-1:0];
      q.data = data;
      pending_requests.push_back(q);
   endtask

   // write start followed by a number of random data words
   task automatic queue_write(int cyl, int sec, int len, int words);
      queue_request(OP_WR_START, cyl, sec, len, {$urandom, $urandom});
      repeat (words) queue_request(OP_WR_DATA, $urandom, $urandom, $urandom, {$urandom, $urandom});
   endtask

   // mostly well-formed commands at valid addresses, some noise and broken writes
   task automatic queue_random_traffic(int n);
      int count, pick, c, s, len, words;
      count = 0;
      while (count < n) begin
         pick = $urandom_range(0, 99);
         if (geo_cylinders == 0 || geo_sectors == 0 || pick < 12) begin
            queue_request(op_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                          {$urandom, $urandom});
            count++;
         end else begin
            c = $urandom_range(0, geo_cylinders - 1);
            s = $urandom_range(0, geo_sectors - 1);
            if (pick < 22) begin
               queue_request(OP_INFO, $urandom, $urandom, $urandom, {$urandom, $urandom});
               count++;
            end else if (pick < 55) begin
               queue_request(OP_READ, c, s, $urandom, {$urandom, $urandom});
               count++;
            end else if (pick < 60) begin
               // stray data word, dropped by the block unless a cut-short write is still pending
               queue_request(OP_WR_DATA, $urandom, $urandom, $urandom, {$urandom, $urandom});
            end else begin
               case ($urandom_range(0, 9))
                  0:       len = 0;
                  1, 2:    len = DEF_SECTOR_BYTES;
                  default: len = $urandom_range(1, DEF_SECTOR_BYTES);
               endcase
               words = (len + 7) / 8;
               // occasionally cut the data short so the next command abandons it
               if (words > 0 && $urandom_range(0, 7) == 0)
                  words = $urandom_range(0, words - 1);
               queue_write(c, s, len, words);
               count += 1 + words;
            end
         end
      end
   endtask

   // register write; block is idle here, so the predictor copy follows at once
   task automatic csr_write(csr_idx_type idx, int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_NUM_CYL:
            geo_cylinders = ((value & 'h7F) > DEF_MAX_CYLINDERS) ? DEF_MAX_CYLINDERS
                                                                 : (value & 'h7F);
         CSR_NUM_SEC:
            geo_sectors = ((value & 'h1F) > DEF_MAX_SECTORS) ? DEF_MAX_SECTORS
                                                             : (value & 'h1F);
         default:
            track_step = value & 'hFFFFF;
      endcase
   endtask

   task automatic set_geometry(int cyl_val, int sec_val, int track_val);
      csr_write(CSR_NUM_CYL, cyl_val);
      csr_write(CSR_NUM_SEC, sec_val);
      csr_write(CSR_TRACK_TIME, track_val);
      setting_count++;
   endtask

   // wait for every request taken and every response back, then let a commit finish
   task automatic wait_until_drained();
      do
         @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_responses.size() != 0);
      repeat (COMMIT_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int cyl_val, int sec_val, int track_val, int gap_in, int gap_out,
                            int n);
      set_geometry(cyl_val, sec_val, track_val);
      req_gap_max = gap_in;
      rsp_gap_max = gap_out;
      queue_random_traffic(n);
      // closing info also ends any write left open
      queue_request(OP_INFO, 0, 0, 0, '0);
      wait_until_drained();
   endtask

   // run limit
   initial begin
      #6_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // stimulus
   initial begin
      foreach (disk_image[i]) disk_image[i] = '0;
      foreach (write_buffer[k]) write_buffer[k] = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset register values
      queue_request(OP_INFO, 0, 0, 0, '0);
      queue_write(63, 15, DEF_SECTOR_BYTES, WORDS_PER_SECTOR);
      queue_request(OP_READ, 63, 15, 0, '0);
      queue_request(OP_WR_START, 0, 0, 0, '0);
      // partial last word: only five bytes of the second word survive
      queue_request(OP_WR_START, 5, 3, 13, '0);
      queue_request(OP_WR_DATA, 0, 0, 0, '1);
      queue_request(OP_WR_DATA, 0, 0, 0, '1);
      queue_request(OP_READ, 5, 3, 0, '0);
      // addresses and lengths just outside the geometry, and the field extremes
      queue_request(OP_READ, 64, 0, 0, '0);
      queue_request(OP_READ, 0, 16, 0, '0);
      queue_request(OP_READ, -1024, 1023, 255, '1);
      queue_request(OP_WR_START, 0, 0, DEF_SECTOR_BYTES + 1, '0);
      queue_request(OP_WR_START, 1023, -1024, -256, '0);
      queue_request(OP_WR_START, 0, 0, 255, '0);
      // data word with nothing pending
      queue_request(OP_WR_DATA, -1, -1, -1, '1);
      // write abandoned by an info, sector stays empty
      queue_write(2, 2, 64, 1);
      queue_request(OP_INFO, 0, 0, 0, '0);
      queue_request(OP_READ, 2, 2, 0, '0);
      wait_until_drained();

      // random phases over several geometries and idle patterns
      run_phase(64, 16, 'hFFFFF, 12, 12, 30);
      run_phase(1, 1, 1, 0, 0, 15);
      run_phase('hFFFFF, 'hFFFFF, $urandom_range(0, 'hFFFFF), 12, 0, 25);
      run_phase(0, 0, 5, 0, 12, 10);

      // response side held off while reads keep coming, so the request side stalls
      set_geometry($urandom_range(1, 64), $urandom_range(1, 16), $urandom_range(0, 'hFFFFF));
      req_gap_max = 0;
      rsp_gap_max = 3;
      fork
         begin
            rsp_blocked = 1'b1;
            repeat (600) @(posedge clock);
            rsp_blocked = 1'b0;
         end
      join_none
      repeat (12)
         queue_request(OP_READ, $urandom_range(0, geo_cylinders - 1),
                       $urandom_range(0, geo_sectors - 1), 0, '0);
      queue_random_traffic(20);
      queue_request(OP_INFO, 0, 0, 0, '0);
      wait_until_drained();

      run_phase(64, 16, $urandom_range(0, 'hFFFFF), 12, 12, 30);

      $display("covered %0d requests over %0d register settings, %0d responses checked",
               request_count, setting_count, response_count);
      $display("  %0d sector reads, %0d write commits, %0d rejected commands",
               read_count, commit_count, reject_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
